[sv/shtm_pkg.sv]
`default_nettype none
package shtm_pkg;

  localparam int FIELD_W = 32;
  localparam int OP_W = 2;
  localparam int AGE_W = 8;
  localparam int COUNT_OUT_W = 6;
  localparam int SCALE_W = 6;
  localparam int NUM_W = FIELD_W + SCALE_W;
  localparam int DEN_W = FIELD_W;

  localparam logic [SCALE_W-1:0] SLOPE_SCALE = 6'd60;

  localparam logic [FIELD_W-1:0] SLOPE_SAT_MAX = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] SLOPE_SAT_MIN = 32'h8000_0000;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_SNAP = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] up;
    logic [FIELD_W-1:0] fr;
    logic [FIELD_W-1:0] mb;
    logic [FIELD_W-1:0] mn;
  } sample_t;

endpackage
`default_nettype wire

[sv/shtm_mem.sv]
`default_nettype none
module shtm_mem #(
  parameter int DEPTH = 60
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire shtm_pkg::sample_t            wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output      shtm_pkg::sample_t            rdata
);
  import shtm_pkg::*;

  sample_t ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= ram[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/shtm_div.sv]
`default_nettype none
module shtm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [shtm_pkg::NUM_W-1:0]    num,
  input  wire logic [shtm_pkg::DEN_W-1:0]    den,
  output      logic                          done,
  output      logic [shtm_pkg::NUM_W-1:0]    quo
);
  import shtm_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    diff = trial - {1'b0, den_r};
    ge = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[sv/sample_history_trend_monitor_core.sv]
// Channel   Handshake            Word
// input     in_valid/in_ready    op, up_sec, free_amt, max_block, free_floor, age_index
// output    out_valid/out_ready  found, held_count, out_*, oldest_*, slope_per_min
//
// Record, unknown op, read miss and empty snapshot go from accept to the result; a read
// adds one read of the history memory. Snapshot: accept, two reads of the history memory,
// then, if count != 1 and dt != 0, a restoring divider, one quotient bit per cycle over 38 bits.
// Reset clears the state, write pointer, count and out_valid; history entries stay unknown until written.
// in_ready is high only when no word is in work; the output register holds a result
// while the next word is accepted and processed.
`default_nettype none
module sample_history_trend_monitor_core #(
  parameter int DEPTH = 60
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic [shtm_pkg::OP_W-1:0]           op,
  input  wire logic [shtm_pkg::FIELD_W-1:0]        up_sec,
  input  wire logic [shtm_pkg::FIELD_W-1:0]        free_amt,
  input  wire logic [shtm_pkg::FIELD_W-1:0]        max_block,
  input  wire logic [shtm_pkg::FIELD_W-1:0]        free_floor,
  input  wire logic [shtm_pkg::AGE_W-1:0]          age_index,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic                                found,
  output      logic [shtm_pkg::COUNT_OUT_W-1:0]    held_count,
  output      logic [shtm_pkg::FIELD_W-1:0]        out_up_sec,
  output      logic [shtm_pkg::FIELD_W-1:0]        out_free_amt,
  output      logic [shtm_pkg::FIELD_W-1:0]        out_max_block,
  output      logic [shtm_pkg::FIELD_W-1:0]        out_min_free,
  output      logic [shtm_pkg::FIELD_W-1:0]        oldest_up_sec,
  output      logic [shtm_pkg::FIELD_W-1:0]        oldest_free_amt,
  output      logic [shtm_pkg::FIELD_W-1:0]        oldest_max_block,
  output      logic [shtm_pkg::FIELD_W-1:0]        oldest_min_free,
  output      logic signed [shtm_pkg::FIELD_W-1:0] slope_per_min
);
  import shtm_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > AGE_W) ? CW : AGE_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [SW-1:0] DEPTH_M1 = SW'(DEPTH - 1);
  localparam logic [AW-1:0] WP_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RD_NEW = 5'b00010,
    S_RD_OLD = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0]      wp;
  logic [CW-1:0]      count;
  logic [OP_W-1:0]    op_r;
  logic               w_found;
  sample_t            w_new;
  sample_t            w_old;
  logic [FIELD_W-1:0] w_slope;
  logic               neg;

  sample_t            live;
  sample_t            mem_rdata;
  logic               mem_we;
  logic               mem_re;
  logic [SW-1:0]      rd_k;
  logic [SW-1:0]      slot_sum;
  logic [AW-1:0]      slot_addr;
  logic               hit;
  logic               accept;
  logic               out_free;

  logic [FIELD_W-1:0] dt;
  logic               rd_neg;
  logic [FIELD_W-1:0] mag;
  logic [NUM_W-1:0]   num;
  logic               slope_go;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;
  logic [FIELD_W-1:0] slope_sat;

  assign live = '{up: up_sec, fr: free_amt, mb: max_block, mn: free_floor};
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign hit = (KW'(age_index) < KW'(count));

  always_comb begin
    if (state == S_RD_NEW) begin
      rd_k = SW'(count - CW'(1));
    end else if (op == OP_SNAP) begin
      rd_k = '0;
    end else begin
      rd_k = SW'(age_index);
    end
    slot_sum = {1'b0, wp} + DEPTH_M1 - rd_k;
    slot_addr = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);
  end

  always_comb begin
    dt = w_new.up - mem_rdata.up;
    rd_neg = (mem_rdata.mb > w_new.mb);
    mag = rd_neg ? (mem_rdata.mb - w_new.mb) : (w_new.mb - mem_rdata.mb);
    num = NUM_W'(mag) * NUM_W'(SLOPE_SCALE);
    slope_go = (count != CW'(1)) && (dt != '0);
  end

  always_comb begin
    if (div_quo[NUM_W-1:FIELD_W-1] != '0) begin
      slope_sat = neg ? SLOPE_SAT_MIN : SLOPE_SAT_MAX;
    end else begin
      slope_sat = neg ? (~div_quo[FIELD_W-1:0] + FIELD_W'(1)) : div_quo[FIELD_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_re = 1'b0;
    div_start = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DONE;
          case (op)
            OP_RECORD: begin
              mem_we = 1'b1;
            end
            OP_READ: begin
              if (hit) begin
                mem_re = 1'b1;
                state_next = S_RD_NEW;
              end
            end
            OP_SNAP: begin
              if (count != '0) begin
                mem_re = 1'b1;
                state_next = S_RD_NEW;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_RD_NEW: begin
        if (op_r == OP_SNAP) begin
          mem_re = 1'b1;
          state_next = S_RD_OLD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RD_OLD: begin
        if (slope_go) begin
          div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  shtm_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata (live),
    .re    (mem_re),
    .raddr (slot_addr),
    .rdata (mem_rdata)
  );

  shtm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (dt),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp <= '0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && op == OP_RECORD) begin
        wp <= (wp == WP_LAST) ? '0 : wp + AW'(1);
        if (count != COUNT_FULL) begin
          count <= count + CW'(1);
        end
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r <= op;
          w_slope <= '0;
          w_found <= (op == OP_RECORD) || (op == OP_SNAP) || (op == OP_READ && hit);
          w_new <= ((op == OP_RECORD) || (op == OP_SNAP && count == '0)) ? live : '0;
          w_old <= (op == OP_SNAP && count == '0) ? live : '0;
        end
      end
      S_RD_NEW: begin
        w_new <= mem_rdata;
      end
      S_RD_OLD: begin
        w_old <= mem_rdata;
        neg <= rd_neg;
      end
      S_DIV: begin
        if (div_done) begin
          w_slope <= slope_sat;
        end
      end
      S_DONE: begin
        if (out_free) begin
          found <= w_found;
          held_count <= COUNT_OUT_W'(count);
          out_up_sec <= w_new.up;
          out_free_amt <= w_new.fr;
          out_max_block <= w_new.mb;
          out_min_free <= w_new.mn;
          oldest_up_sec <= w_old.up;
          oldest_free_amt <= w_old.fr;
          oldest_max_block <= w_old.mb;
          oldest_min_free <= w_old.mn;
          slope_per_min <= w_slope;
        end
      end
      default: begin
        op_r <= op_r;
      end
    endcase
  end

endmodule
`default_nettype wire
